FILE: hw/rtl/vvtc_pkg.sv
// Package for the vertical timing calculator: constants, codes and sequencer states.
package vvtc_pkg;

  localparam int unsigned DvdW  = 25;  // pixel clock dividend width
  localparam int unsigned DivW  = 18;  // htotal * 8 * rate divisor width
  localparam int unsigned ProdW = 15;  // htotal * rate product width
  localparam int unsigned CntW  = 5;   // division step counter width

  localparam logic [DvdW-1:0] ClkLow  = 25'd25175000;
  localparam logic [DvdW-1:0] ClkHigh = 25'd28322000;

  localparam logic [7:0]  ClkSelMask = 8'h0C;
  localparam logic [7:0]  RateMin    = 8'd50;
  localparam logic [7:0]  RateMax    = 8'd120;
  localparam logic [7:0]  RateReset  = 8'd60;
  localparam logic [7:0]  HtotalAdj  = 8'd5;
  localparam logic [10:0] VtMargin   = 11'd13;
  localparam logic [10:0] VsOffset   = 11'd3;
  localparam logic [10:0] VeOffset   = 11'd2;
  localparam logic [9:0]  VtAdj      = 10'd2;
  localparam logic [7:0]  OvfVtMask  = 8'h21;
  localparam logic [7:0]  OvfVsMask  = 8'h84;
  localparam logic [7:0]  VreKeep    = 8'h70;  // 0x7F & 0xF0
  localparam logic [CntW-1:0] DivSteps = CntW'(DvdW - 1);

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_HOST = 2'd1,
    STATUS_BAD  = 2'd2
  } status_t;

  typedef enum logic {
    CFG_EMULATED_ADAPTER = 1'b0,
    CFG_LINEAR_FB_ACTIVE = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

endpackage

FILE: hw/rtl/vga_vertical_timing_calc_unit.sv
// Top level: VGA vertical timing calculator with a single restoring divider.
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_stall   | rate_hz, misc_byte, htotal_byte, vde_low_byte,
//          |           |                       | overflow_byte, retrace_end_byte
//  out_    | output    | out_valid / out_stall | status, write_regs, vtotal_out, overflow_out,
//          |           |                       | vstart_out, vend_out, current_rate
//  cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// A computed request runs 25 steps of the radix-2 divider (one quotient bit per cycle)
// in ST_DIVIDE, then forms and registers its result in ST_FINISH and returns to idle. A
// rejected rate or a host-timed request goes from idle straight to ST_FINISH. in_stall is
// high while an item is in flight. The result register holds until taken; a finished item
// waits in the last step while the previous result is still stalled. Reset is synchronous
// and sets the stored rate to 60.
module vga_vertical_timing_calc_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rate_hz,
  input  logic [7:0] in_misc_byte,
  input  logic [7:0] in_htotal_byte,
  input  logic [7:0] in_vde_low_byte,
  input  logic [7:0] in_overflow_byte,
  input  logic [7:0] in_retrace_end_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic       out_write_regs,
  output logic [7:0] out_vtotal_out,
  output logic [7:0] out_overflow_out,
  output logic [7:0] out_vstart_out,
  output logic [7:0] out_vend_out,
  output logic [7:0] out_current_rate
);

  vvtc_pkg::state_t state_r, state_nxt;

  logic emulated_r, linear_fb_r;
  logic [7:0] stored_rate_r;

  logic bad_r, host_r;
  logic [7:0] rate_r, ovf_r, vde_low_r, vre_r;
  logic [vvtc_pkg::DivW-1:0] div_r;
  logic [vvtc_pkg::DvdW-1:0] dvd_r;
  logic [vvtc_pkg::DivW-1:0] rem_r;
  logic [vvtc_pkg::CntW-1:0] cnt_r;

  logic out_valid_r, out_wr_r;
  logic [1:0] out_status_r;
  logic [7:0] out_vt_r, out_ov_r, out_vs_r, out_ve_r, out_rate_r;

  logic in_xfer, load_out, div_step, div_last;

  logic rate_ok, host_now;
  logic [8:0] ht_now;
  logic [16:0] prod_now;

  // Sequencer control
  assign in_xfer  = in_valid && (state_r == vvtc_pkg::ST_IDLE);
  assign div_last = (cnt_r == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vvtc_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (rate_ok && !host_now) state_nxt = vvtc_pkg::ST_DIVIDE;
          else state_nxt = vvtc_pkg::ST_FINISH;
        end
      end
      vvtc_pkg::ST_DIVIDE: begin
        if (div_last) state_nxt = vvtc_pkg::ST_FINISH;
      end
      vvtc_pkg::ST_FINISH: begin
        if (!out_valid_r || !out_stall) state_nxt = vvtc_pkg::ST_IDLE;
      end
      default: state_nxt = vvtc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    div_step = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      vvtc_pkg::ST_IDLE:   in_stall = 1'b0;
      vvtc_pkg::ST_DIVIDE: div_step = 1'b1;
      vvtc_pkg::ST_FINISH: load_out = !out_valid_r || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  // Request classification at transfer
  assign rate_ok  = (in_rate_hz >= vvtc_pkg::RateMin) && (in_rate_hz <= vvtc_pkg::RateMax);
  assign host_now = emulated_r && linear_fb_r;
  assign ht_now   = {1'b0, in_htotal_byte} + {1'b0, vvtc_pkg::HtotalAdj};
  assign prod_now = ht_now * in_rate_hz;

  // One restoring division step
  logic [vvtc_pkg::DivW:0] partial, diff;
  assign partial = {rem_r, dvd_r[vvtc_pkg::DvdW-1]};
  assign diff    = partial - {1'b0, div_r};

  // Result formation from the quotient
  logic [10:0] vde, vs, ve, vt_min;
  logic [9:0]  vt;
  logic        fit, calc_ok;
  logic [7:0]  ov_new;
  vvtc_pkg::status_t status_now;

  assign vde    = {1'b0, ovf_r[6], ovf_r[1], vde_low_r} + 11'd1;
  assign vs     = vde + vvtc_pkg::VsOffset;
  assign ve     = vs + vvtc_pkg::VeOffset;
  assign vt_min = vde + vvtc_pkg::VtMargin;
  assign fit    = (dvd_r[vvtc_pkg::DvdW-1:10] == '0) && (dvd_r[10:0] >= vt_min)
                  && (ve < dvd_r[10:0]);
  assign calc_ok = !bad_r && !host_r && fit;
  assign vt      = dvd_r[9:0] - vvtc_pkg::VtAdj;
  assign ov_new  = (ovf_r & ~(vvtc_pkg::OvfVtMask | vvtc_pkg::OvfVsMask))
                   | {vs[9], 1'b0, vt[9], 2'b00, vs[8], 1'b0, vt[8]};

  always_comb begin
    priority if (bad_r) status_now = vvtc_pkg::STATUS_BAD;
    else if (host_r)    status_now = vvtc_pkg::STATUS_HOST;
    else if (fit)       status_now = vvtc_pkg::STATUS_OK;
    else                status_now = vvtc_pkg::STATUS_BAD;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= vvtc_pkg::ST_IDLE;
      emulated_r    <= 1'b0;
      linear_fb_r   <= 1'b0;
      stored_rate_r <= vvtc_pkg::RateReset;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (vvtc_pkg::cfg_idx_t'(cfg_index))
          vvtc_pkg::CFG_EMULATED_ADAPTER: emulated_r  <= cfg_wdata;
          vvtc_pkg::CFG_LINEAR_FB_ACTIVE: linear_fb_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (load_out && (host_r || calc_ok) && !bad_r) stored_rate_r <= rate_r;
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      bad_r     <= !rate_ok;
      host_r    <= rate_ok && host_now;
      rate_r    <= in_rate_hz;
      ovf_r     <= in_overflow_byte;
      vde_low_r <= in_vde_low_byte;
      vre_r     <= in_retrace_end_byte;
      div_r     <= {prod_now[vvtc_pkg::ProdW-1:0], 3'b000};
      dvd_r     <= ((in_misc_byte & vvtc_pkg::ClkSelMask) == '0) ? vvtc_pkg::ClkLow
                                                                  : vvtc_pkg::ClkHigh;
      rem_r     <= '0;
      cnt_r     <= vvtc_pkg::DivSteps;
    end else if (div_step) begin
      rem_r <= diff[vvtc_pkg::DivW] ? partial[vvtc_pkg::DivW-1:0] : diff[vvtc_pkg::DivW-1:0];
      dvd_r <= {dvd_r[vvtc_pkg::DvdW-2:0], ~diff[vvtc_pkg::DivW]};
      cnt_r <= cnt_r - 1'b1;
    end
    if (load_out) begin
      out_status_r <= status_now;
      out_wr_r     <= calc_ok;
      out_vt_r     <= calc_ok ? vt[7:0] : 8'h00;
      out_ov_r     <= calc_ok ? ov_new : 8'h00;
      out_vs_r     <= calc_ok ? vs[7:0] : 8'h00;
      out_ve_r     <= calc_ok ? ((vre_r & vvtc_pkg::VreKeep) | {4'h0, ve[3:0]}) : 8'h00;
      out_rate_r   <= ((host_r || calc_ok) && !bad_r) ? rate_r : stored_rate_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_write_regs   = out_wr_r;
  assign out_vtotal_out   = out_vt_r;
  assign out_overflow_out = out_ov_r;
  assign out_vstart_out   = out_vs_r;
  assign out_vend_out     = out_ve_r;
  assign out_current_rate = out_rate_r;

endmodule

FILE: hw/rtl/vvtc_checker.sv
// Port-level checker for the vertical timing calculator, bound to the top level.
module vvtc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_status,
  input logic       out_write_regs,
  input logic [7:0] out_vtotal_out,
  input logic [7:0] out_overflow_out,
  input logic [7:0] out_vstart_out,
  input logic [7:0] out_vend_out
);

  // A stalled result stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Only one item in flight: busy right after an input transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == vvtc_pkg::STATUS_OK) || (out_status == vvtc_pkg::STATUS_HOST)
                  || (out_status == vvtc_pkg::STATUS_BAD))
    else $error("undefined status code");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_write_regs == (out_status == vvtc_pkg::STATUS_OK)))
    else $error("write_regs disagrees with status");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_regs |-> out_vtotal_out == 8'h00 && out_overflow_out == 8'h00
                                     && out_vstart_out == 8'h00 && out_vend_out == 8'h00)
    else $error("register bytes not cleared on a result without writes");

endmodule

bind vga_vertical_timing_calc_unit vvtc_checker u_vvtc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_write_regs   (out_write_regs),
  .out_vtotal_out   (out_vtotal_out),
  .out_overflow_out (out_overflow_out),
  .out_vstart_out   (out_vstart_out),
  .out_vend_out     (out_vend_out)
);
